[design/twp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and small tables for the turn-then-line waypoint generator.
// Depends on nothing; every other file of the block imports it.
package twp_pkg;

    localparam int POS_W       = 32;
    localparam int ANG_W       = 16;
    localparam int IDX_W       = 5;
    localparam int CW          = 36;
    localparam int ZW          = 32;
    localparam int ITERS       = 20;
    localparam int NORM_STEPS  = 6;
    localparam int REM_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int DATA_IN_W   = 160;
    localparam int DATA_OUT_W  = 88;
    localparam int OUT_PAD_W   = DATA_OUT_W - 2 * POS_W - ANG_W - IDX_W;
    localparam int IDX_LSB     = 2 * POS_W + ANG_W;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_PREP,
        FS_NORM,
        FS_ROT,
        FS_HEAD,
        FS_TURN,
        FS_MUL,
        FS_SPLIT,
        FS_PUSH
    } front_state_t;

    typedef struct packed {
        logic             neg;
        logic [POS_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } axis_split_t;

    typedef struct packed {
        logic             neg;
        logic [ANG_W-1:0] quo;
        logic [REM_W-1:0] rem;
    } turn_split_t;

    typedef struct packed {
        logic [POS_W-1:0] start_x;
        logic [POS_W-1:0] start_y;
        logic [ANG_W-1:0] start_yaw;
        logic [POS_W-1:0] goal_x;
        logic [POS_W-1:0] goal_y;
        logic [ANG_W-1:0] goal_yaw;
        logic [ANG_W-1:0] heading;
        turn_split_t      turn;
        axis_split_t      line_x;
        axis_split_t      line_y;
    } job_t;

    function automatic logic [ZW-1:0] atan_entry(input logic [4:0] i);
        logic [ZW-1:0] v;
        case (i)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Normalization runs as a greedy shift search: 16, 8, 4, 2, 1, then a final 1.
    function automatic logic [4:0] norm_amt(input logic [2:0] step);
        logic [4:0] v;
        case (step)
            3'd0:    v = 5'd16;
            3'd1:    v = 5'd8;
            3'd2:    v = 5'd4;
            3'd3:    v = 5'd2;
            default: v = 5'd1;
        endcase
        return v;
    endfunction

    function automatic logic [4:0] norm_exp(input logic [2:0] step);
        logic [4:0] v;
        case (step)
            3'd0:    v = 5'd15;
            3'd1:    v = 5'd23;
            3'd2:    v = 5'd27;
            3'd3:    v = 5'd29;
            3'd4:    v = 5'd30;
            default: v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

[design/twp_front.sv]
`timescale 1ns / 1ps
// Front end: takes a pose pair, finds the heading with a vectoring CORDIC and splits
// the deltas and the turn into quotient and remainder per step. Depends on twp_pkg.
module twp_front import twp_pkg::*;
#(
    parameter int TURN_POINTS = 10,
    parameter int LINE_POINTS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DATA_IN_W-1:0] in_data,
    output logic                 job_valid,
    input  logic                 job_ready,
    output job_t                 job
);

    localparam int DRW       = $clog2(4 * LINE_POINTS);
    localparam int DIV_STEPS = POS_W / 2;
    localparam int DCW       = $clog2(DIV_STEPS + 1);
    localparam logic [DRW-1:0] L_DIV1 = DRW'(LINE_POINTS);
    localparam logic [DRW-1:0] L_DIV2 = DRW'(2 * LINE_POINTS);
    localparam logic [DRW-1:0] L_DIV3 = DRW'(3 * LINE_POINTS);
    localparam int RS = ANG_W + $clog2(TURN_POINTS);
    localparam logic [RS:0] RECIP =
        (RS + 1)'(((longint'(1) << RS) + longint'(TURN_POINTS) - 1) / longint'(TURN_POINTS));
    localparam logic [ANG_W-1:0] T_DIV = ANG_W'(TURN_POINTS);

    front_state_t state_reg, state_next;

    logic [POS_W-1:0] sx_reg, sy_reg, gx_reg, gy_reg;
    logic [ANG_W-1:0] syaw_reg, gyaw_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic [POS_W-1:0] ay_reg;
    logic [ZW-1:0]    z_reg;
    logic             zero_reg;
    logic [4:0]       step_reg;
    logic [ANG_W-1:0] head_reg, tmag_reg, tq_reg;
    logic             tneg_reg;
    logic [REM_W-1:0] tb_reg;
    logic             xneg_reg, yneg_reg;

    logic [POS_W-1:0] div_d_reg [2];
    logic [DRW-1:0]   div_r_reg [2];
    logic [DCW-1:0]   div_cnt_reg;

    logic accept;
    logic [POS_W:0] dx, dy, ndx, ndy;
    logic signed [POS_W:0] yv;
    logic [POS_W-1:0] ax, ay, mv;
    logic [ZW-1:0] z_round;
    logic [ANG_W-1:0] turn_raw, tq_times;
    logic [ANG_W+RS:0] prod;
    logic signed [CW-1:0] xs, ys;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        job_valid  = 1'b0;
        case (state_reg)
            FS_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = FS_PREP;
                end
            end
            FS_PREP:  state_next = FS_NORM;
            FS_NORM:
            begin
                if (step_reg == 5'(NORM_STEPS - 1))
                begin
                    state_next = FS_ROT;
                end
            end
            FS_ROT:
            begin
                if (step_reg == 5'(ITERS - 1))
                begin
                    state_next = FS_HEAD;
                end
            end
            FS_HEAD:  state_next = FS_TURN;
            FS_TURN:  state_next = FS_MUL;
            FS_MUL:   state_next = FS_SPLIT;
            FS_SPLIT: state_next = FS_PUSH;
            FS_PUSH:
            begin
                job_valid = 1'b1;
                in_ready  = job_ready;
                if (job_ready)
                begin
                    state_next = in_valid ? FS_PREP : FS_IDLE;
                end
            end
            default:  state_next = FS_IDLE;
        endcase
    end

    assign dx  = {gx_reg[POS_W-1], gx_reg} - {sx_reg[POS_W-1], sx_reg};
    assign dy  = {gy_reg[POS_W-1], gy_reg} - {sy_reg[POS_W-1], sy_reg};
    assign ndx = {sx_reg[POS_W-1], sx_reg} - {gx_reg[POS_W-1], gx_reg};
    assign ndy = {sy_reg[POS_W-1], sy_reg} - {gy_reg[POS_W-1], gy_reg};
    assign ax  = dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
    assign ay  = dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
    assign yv  = dx[POS_W] ? signed'(ndy) : signed'(dy);
    assign mv  = x_reg[POS_W-1:0] | ay_reg;
    assign xs  = x_reg >>> step_reg;
    assign ys  = y_reg >>> step_reg;
    assign z_round  = z_reg + 32'h0000_8000;
    assign turn_raw = head_reg - syaw_reg;
    assign prod     = (ANG_W + RS + 1)'(tmag_reg) * (ANG_W + RS + 1)'(RECIP);
    assign tq_times = tq_reg * T_DIV;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg   <= in_data[31:0];
            sy_reg   <= in_data[63:32];
            syaw_reg <= in_data[79:64];
            gx_reg   <= in_data[111:80];
            gy_reg   <= in_data[143:112];
            gyaw_reg <= in_data[159:144];
        end
        case (state_reg)
            FS_PREP:
            begin
                x_reg    <= CW'(ax);
                y_reg    <= CW'(yv);
                ay_reg   <= ay;
                z_reg    <= dx[POS_W] ? 32'h8000_0000 : 32'h0000_0000;
                zero_reg <= (dx == '0) && (dy == '0);
                xneg_reg <= dx[POS_W];
                yneg_reg <= dy[POS_W];
                step_reg <= '0;
            end
            FS_NORM:
            begin
                if ((mv >> norm_exp(step_reg[2:0])) == '0)
                begin
                    x_reg  <= x_reg <<< norm_amt(step_reg[2:0]);
                    y_reg  <= y_reg <<< norm_amt(step_reg[2:0]);
                    ay_reg <= ay_reg << norm_amt(step_reg[2:0]);
                end
                step_reg <= (step_reg == 5'(NORM_STEPS - 1)) ? '0 : step_reg + 5'd1;
            end
            FS_ROT:
            begin
                if (!y_reg[CW-1])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_entry(step_reg);
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_entry(step_reg);
                end
                step_reg <= step_reg + 5'd1;
            end
            FS_HEAD:
            begin
                head_reg <= zero_reg ? '0 : z_round[ZW-1:ZW-ANG_W];
            end
            FS_TURN:
            begin
                // A turn of exactly half a circle counts as positive.
                tneg_reg <= turn_raw[ANG_W-1] && (turn_raw != 16'h8000);
                tmag_reg <= (turn_raw[ANG_W-1] && (turn_raw != 16'h8000))
                            ? (~turn_raw + 16'd1) : turn_raw;
            end
            FS_MUL:
            begin
                tq_reg <= ANG_W'(prod >> RS);
            end
            FS_SPLIT:
            begin
                tb_reg <= REM_W'(tmag_reg - tq_times);
            end
            default:
            begin
            end
        endcase
    end

    // Radix-4 division of both delta magnitudes by the line point count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (state_reg == FS_PREP)
        begin
            div_cnt_reg <= DCW'(DIV_STEPS);
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FS_PREP)
        begin
            div_d_reg[0] <= ax;
            div_d_reg[1] <= ay;
            div_r_reg[0] <= '0;
            div_r_reg[1] <= '0;
        end
        else if (div_cnt_reg != '0)
        begin
            for (int n = 0; n < 2; n++)
            begin
                logic [DRW-1:0] r4;
                r4 = DRW'({div_r_reg[n], div_d_reg[n][POS_W-1:POS_W-2]});
                if (r4 >= L_DIV3)
                begin
                    div_r_reg[n] <= r4 - L_DIV3;
                    div_d_reg[n] <= {div_d_reg[n][POS_W-3:0], 2'd3};
                end
                else if (r4 >= L_DIV2)
                begin
                    div_r_reg[n] <= r4 - L_DIV2;
                    div_d_reg[n] <= {div_d_reg[n][POS_W-3:0], 2'd2};
                end
                else if (r4 >= L_DIV1)
                begin
                    div_r_reg[n] <= r4 - L_DIV1;
                    div_d_reg[n] <= {div_d_reg[n][POS_W-3:0], 2'd1};
                end
                else
                begin
                    div_r_reg[n] <= r4;
                    div_d_reg[n] <= {div_d_reg[n][POS_W-3:0], 2'd0};
                end
            end
        end
    end

    always_comb
    begin
        job.start_x    = sx_reg;
        job.start_y    = sy_reg;
        job.start_yaw  = syaw_reg;
        job.goal_x     = gx_reg;
        job.goal_y     = gy_reg;
        job.goal_yaw   = gyaw_reg;
        job.heading    = head_reg;
        job.turn.neg   = tneg_reg;
        job.turn.quo   = tq_reg;
        job.turn.rem   = tb_reg;
        job.line_x.neg = xneg_reg;
        job.line_x.quo = div_d_reg[0];
        job.line_x.rem = REM_W'(div_r_reg[0]);
        job.line_y.neg = yneg_reg;
        job.line_y.quo = div_d_reg[1];
        job.line_y.rem = REM_W'(div_r_reg[1]);
    end

endmodule

[design/twp_queue.sv]
`timescale 1ns / 1ps
// Short register queue of classified jobs between the front end and the back end.
// Depends on twp_pkg for the job type and the depth.
module twp_queue import twp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    job_t mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != CNW'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

[design/twp_back.sv]
`timescale 1ns / 1ps
// Back end: walks one job through its turn points, line points and goal point,
// stepping rounded offsets incrementally. Depends on twp_pkg.
module twp_back import twp_pkg::*;
#(
    parameter int TURN_POINTS = 10,
    parameter int LINE_POINTS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_ready,
    input  job_t                  job,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_OUT_W-1:0] out_data,
    output logic                  out_last
);

    localparam int TOTAL = TURN_POINTS + LINE_POINTS + 1;
    localparam int KW    = $clog2(TOTAL);
    localparam int TRW   = $clog2(2 * TURN_POINTS);
    localparam int LRW   = $clog2(2 * LINE_POINTS);
    localparam logic [TRW-1:0] T_DIV  = TRW'(TURN_POINTS);
    localparam logic [TRW-1:0] T_HALF = TRW'(TURN_POINTS / 2);
    localparam logic [LRW-1:0] L_DIV  = LRW'(LINE_POINTS);
    localparam logic [LRW-1:0] L_HALF = LRW'(LINE_POINTS / 2);
    localparam logic [KW-1:0]  K_TURN_END = KW'(TURN_POINTS);
    localparam logic [KW-1:0]  K_LAST     = KW'(TOTAL - 1);

    function automatic logic [POS_W+LRW-1:0] line_step(input logic [POS_W-1:0] q,
                                                        input logic [LRW-1:0]   r,
                                                        input axis_split_t      s);
        logic [LRW-1:0] sum;
        logic           c;
        sum = r + LRW'(s.rem);
        c   = sum >= L_DIV;
        return {q + s.quo + POS_W'(c), c ? sum - L_DIV : sum};
    endfunction

    job_t             job_reg;
    logic             active_reg;
    logic [KW-1:0]    k_reg;
    logic [ANG_W-1:0] tq_reg;
    logic [TRW-1:0]   tr_reg;
    logic [POS_W-1:0] xq_reg, yq_reg;
    logic [LRW-1:0]   xr_reg, yr_reg;
    logic             out_valid_reg, out_last_reg;
    logic [POS_W-1:0] ox_reg, oy_reg;
    logic [ANG_W-1:0] oyaw_reg;
    logic [IDX_W-1:0] oidx_reg;

    logic emit, is_last, in_turn, in_line, load;
    logic [TRW-1:0] t_sum;
    logic t_carry;
    logic [POS_W+LRW-1:0] x_first, y_first, x_step, y_step;

    assign emit      = active_reg && (!out_valid_reg || out_ready);
    assign is_last   = k_reg == K_LAST;
    assign in_turn   = k_reg < K_TURN_END;
    assign in_line   = !in_turn && !is_last;
    assign job_ready = !active_reg || (emit && is_last);
    assign load      = job_valid && job_ready;

    assign t_sum   = tr_reg + TRW'(job_reg.turn.rem);
    assign t_carry = t_sum >= T_DIV;
    assign x_first = line_step('0, L_HALF, job.line_x);
    assign y_first = line_step('0, L_HALF, job.line_y);
    assign x_step  = line_step(xq_reg, xr_reg, job_reg.line_x);
    assign y_step  = line_step(yq_reg, yr_reg, job_reg.line_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                active_reg <= 1'b1;
                k_reg      <= '0;
            end
            else if (emit)
            begin
                if (is_last)
                begin
                    active_reg <= 1'b0;
                end
                k_reg <= k_reg + KW'(1);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
            tq_reg  <= '0;
            tr_reg  <= T_HALF;
            {xq_reg, xr_reg} <= x_first;
            {yq_reg, yr_reg} <= y_first;
        end
        else if (emit && in_turn)
        begin
            tq_reg <= tq_reg + job_reg.turn.quo + ANG_W'(t_carry);
            tr_reg <= t_carry ? t_sum - T_DIV : t_sum;
        end
        else if (emit && in_line)
        begin
            {xq_reg, xr_reg} <= x_step;
            {yq_reg, yr_reg} <= y_step;
        end

        if (emit)
        begin
            oidx_reg     <= IDX_W'(k_reg);
            out_last_reg <= is_last;
            if (in_turn)
            begin
                ox_reg   <= job_reg.start_x;
                oy_reg   <= job_reg.start_y;
                oyaw_reg <= job_reg.start_yaw
                            + (tq_reg ^ {ANG_W{job_reg.turn.neg}})
                            + ANG_W'(job_reg.turn.neg);
            end
            else if (in_line)
            begin
                ox_reg   <= job_reg.start_x + (xq_reg ^ {POS_W{job_reg.line_x.neg}})
                            + POS_W'(job_reg.line_x.neg);
                oy_reg   <= job_reg.start_y + (yq_reg ^ {POS_W{job_reg.line_y.neg}})
                            + POS_W'(job_reg.line_y.neg);
                oyaw_reg <= job_reg.heading;
            end
            else
            begin
                ox_reg   <= job_reg.goal_x;
                oy_reg   <= job_reg.goal_y;
                oyaw_reg <= job_reg.goal_yaw;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {{OUT_PAD_W{1'b0}}, oidx_reg, oyaw_reg, oy_reg, ox_reg};

endmodule

[design/turn_then_line_waypoint_generator.sv]
`timescale 1ns / 1ps
// Top level of the turn-then-line waypoint generator.
// Depends on twp_pkg, twp_front, twp_queue and twp_back.

// Each accepted pose pair yields TURN_POINTS + LINE_POINTS + 1 waypoints, one per
// cycle while the sink is ready: turn points at the start position, line points
// toward the goal, then the goal pose with tlast set. Per pose pair the front end runs
// a setup step, six normalization steps and 20 CORDIC rotations for the heading,
// then a turn division in its turn, multiply and split states, so with default
// parameters the front end paces a continuous input stream; with longer paths the
// output, at one waypoint per cycle, sets the rate. The next pose pair is taken while
// a path is still streaming out, and up to two finished pose pairs wait in a queue.
module turn_then_line_waypoint_generator import twp_pkg::*;
#(
    parameter int TURN_POINTS = 10,
    parameter int LINE_POINTS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_x, start_y, start_yaw, goal_x, goal_y, goal_yaw
    input  logic [DATA_IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // way_x, way_y, way_yaw, point_index, zero fill
    output logic [DATA_OUT_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    job_t front_job, back_job;
    logic front_valid, front_ready, back_valid, back_ready;

    twp_front #(
        .TURN_POINTS(TURN_POINTS),
        .LINE_POINTS(LINE_POINTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    twp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    twp_back #(
        .TURN_POINTS(TURN_POINTS),
        .LINE_POINTS(LINE_POINTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

[design/twp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the waypoint generator, attached to the top level by bind.
// Depends on twp_pkg and on the top level's port list.
module twp_checker import twp_pkg::*;
#(
    parameter int TURN_POINTS = 10,
    parameter int LINE_POINTS = 10
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [DATA_OUT_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    localparam int TOTAL = TURN_POINTS + LINE_POINTS + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL - 1);

    logic in_xfer, out_xfer;
    logic [IDX_W-1:0] idx, exp_idx_reg;
    logic [3:0] pending_reg;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign idx      = m_axis_tdata[IDX_LSB+IDX_W-1:IDX_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (out_xfer)
            begin
                exp_idx_reg <= m_axis_tlast ? '0 : exp_idx_reg + IDX_W'(1);
            end
            pending_reg <= pending_reg + 4'(in_xfer) - 4'(out_xfer && m_axis_tlast);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled output transfer changed.");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> idx == exp_idx_reg)
        else $error("Waypoint index out of sequence.");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && m_axis_tlast |-> idx == LAST_IDX)
        else $error("Path ended at the wrong waypoint.");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> pending_reg != '0)
        else $error("Waypoint sent with no pose pair outstanding.");

endmodule

bind turn_then_line_waypoint_generator twp_checker #(
    .TURN_POINTS(TURN_POINTS),
    .LINE_POINTS(LINE_POINTS)
) u_twp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
